// File: hw/rtl/mws_pkg.sv
// Package for the magnetometer window sum block.
// Holds field widths, status bit positions, lane control struct and helpers.
// No dependencies.
package mws_pkg;

  localparam int unsigned STATUS_W = 8;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W    = 24;

  // Status bit positions inside the two status bytes.
  localparam int unsigned READY_BIT    = 0;
  localparam int unsigned OVERFLOW_BIT = 3;

  localparam int unsigned DEFAULT_WINDOW_DEPTH = 256;

  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // Control shared by all axis lanes.
  typedef struct packed {
    logic load;         // read the leaving entry and capture the new sample
    logic store;        // write the new sample into the ring
    logic update;       // apply the slide to the running total
    logic leave_valid;  // the leaving entry has been written since reset
  } lane_ctrl_t;

  function automatic sum_t sext_sample(input sample_t s);
    return {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
  endfunction

endpackage

// File: hw/rtl/mws_lane.sv
// One axis lane: sample ring memory and running sum for that axis.
// Depends on mws_pkg.
module mws_lane #(
  parameter int unsigned DEPTH = mws_pkg::DEFAULT_WINDOW_DEPTH,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mws_pkg::lane_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    addr,
  input  mws_pkg::sample_t    sample,
  output mws_pkg::sum_t       total
);

  mws_pkg::sample_t ring_mem [DEPTH];
  mws_pkg::sample_t leave_r;
  mws_pkg::sample_t enter_r;
  mws_pkg::sum_t    total_r;
  mws_pkg::sum_t    total_nxt;
  mws_pkg::sum_t    leave_ext;

  // Read-before-write: the load captures the entry that the store replaces.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      leave_r <= ring_mem[addr];
      enter_r <= sample;
    end
    if (ctrl.store) begin
      ring_mem[addr] <= sample;
    end
  end

  // An entry never written since reset counts as zero.
  assign leave_ext = ctrl.leave_valid ? mws_pkg::sext_sample(leave_r) : '0;
  assign total_nxt = total_r - leave_ext + mws_pkg::sext_sample(enter_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (ctrl.update) begin
      total_r <= total_nxt;
    end
  end

  assign total = total_r;

endmodule

// File: hw/rtl/mws_merge.sv
// Output stage: merges the three lane sums with the accepted flag into one result.
// Depends on mws_pkg.
module mws_merge (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          move,
  input  logic          accepted_in,
  input  mws_pkg::sum_t lane_x,
  input  mws_pkg::sum_t lane_y,
  input  mws_pkg::sum_t lane_z,
  input  logic          out_ready,
  output logic          out_valid,
  output logic          out_accepted,
  output mws_pkg::sum_t out_sum_x,
  output mws_pkg::sum_t out_sum_y,
  output mws_pkg::sum_t out_sum_z
);

  logic out_valid_r;
  logic out_valid_nxt;
  logic accepted_r;

  always_comb begin
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      accepted_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (move) begin
        accepted_r <= accepted_in;
      end
    end
  end

  // Lane totals change only when a new result moves in, so they hold with it.
  assign out_valid    = out_valid_r;
  assign out_accepted = accepted_r;
  assign out_sum_x    = lane_x;
  assign out_sum_y    = lane_y;
  assign out_sum_z    = lane_z;

endmodule

// File: hw/rtl/magnetometer_window_sum_top.sv
// Top level of the magnetometer window sum (moving boxcar sum) block.
// Depends on mws_pkg, mws_lane and mws_merge.

// The block takes one magnetometer frame per transaction and returns one result
// per frame: the running sums of the last WINDOW_DEPTH accepted x, y and z
// samples plus an accepted flag. A frame enters the window only when bit 0 of
// the ready status is set and bit 3 of the overflow status is clear; sensor
// axis a maps to y, b to z and c to x. A rejected frame leaves rings, pointer
// and sums alone; its result repeats the current sums with accepted low. The
// block takes one frame every clock cycle while out_ready is high. A frame
// waits in stage one and moves into the output register, raising out_valid,
// once that register is empty or being emptied. That rate rests on the add
// and subtract loop on each running total and on each lane's ring memory doing
// one read and one write per frame. The rings need no clearing pass after
// reset: they fill in order, so a single fill flag tells whether the entry
// being replaced has been written yet, and unwritten entries count as zero.
module magnetometer_window_sum_top #(
  parameter int unsigned WINDOW_DEPTH = mws_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mws_pkg::status_t    in_ready_status,
  input  mws_pkg::sample_t    in_axis_a,
  input  mws_pkg::sample_t    in_axis_b,
  input  mws_pkg::sample_t    in_axis_c,
  input  mws_pkg::status_t    in_overflow_status,
  output logic                out_valid,
  input  logic                out_ready,
  output mws_pkg::sum_t       out_sum_x,
  output mws_pkg::sum_t       out_sum_y,
  output mws_pkg::sum_t       out_sum_z,
  output logic                out_accepted
);

  localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

  logic               frame_ok;
  logic               accept;
  logic               move1;
  logic [IDX_W-1:0]   wr_idx_r;
  logic [IDX_W-1:0]   wr_idx_nxt;
  logic               full_r;
  logic               full_nxt;
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic               s1_ok_r;
  logic               s1_full_r;
  mws_pkg::lane_ctrl_t lane_ctrl;
  mws_pkg::sum_t      lane_x;
  mws_pkg::sum_t      lane_y;
  mws_pkg::sum_t      lane_z;

  // Only the two status bits matter; all other status bits are ignored.
  assign frame_ok = in_ready_status[mws_pkg::READY_BIT]
                 && !in_overflow_status[mws_pkg::OVERFLOW_BIT];

  // Stage one holds the frame while its leaving samples are read. It moves on
  // whenever the output register is empty or being emptied this cycle.
  assign move1    = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || move1;
  assign accept   = in_valid && in_ready;

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    full_nxt   = full_r;
    if (accept && frame_ok) begin
      if (wr_idx_r == LAST_IDX) begin
        wr_idx_nxt = '0;
        full_nxt   = 1'b1;
      end else begin
        wr_idx_nxt = wr_idx_r + 1'b1;
      end
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (move1) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r   <= '0;
      full_r     <= 1'b0;
      s1_valid_r <= 1'b0;
      s1_ok_r    <= 1'b0;
      s1_full_r  <= 1'b0;
    end else begin
      wr_idx_r   <= wr_idx_nxt;
      full_r     <= full_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        s1_ok_r   <= frame_ok;
        s1_full_r <= full_r;
      end
    end
  end

  always_comb begin
    lane_ctrl.load        = accept;
    lane_ctrl.store       = accept && frame_ok;
    lane_ctrl.update      = move1 && s1_ok_r;
    lane_ctrl.leave_valid = s1_full_r;
  end

  // Axis remap: sensor axis c is x, a is y, b is z.
  mws_lane #(.DEPTH(WINDOW_DEPTH)) u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (lane_ctrl),
    .addr   (wr_idx_r),
    .sample (in_axis_c),
    .total  (lane_x)
  );

  mws_lane #(.DEPTH(WINDOW_DEPTH)) u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (lane_ctrl),
    .addr   (wr_idx_r),
    .sample (in_axis_a),
    .total  (lane_y)
  );

  mws_lane #(.DEPTH(WINDOW_DEPTH)) u_lane_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (lane_ctrl),
    .addr   (wr_idx_r),
    .sample (in_axis_b),
    .total  (lane_z)
  );

  mws_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .move         (move1),
    .accepted_in  (s1_ok_r),
    .lane_x       (lane_x),
    .lane_y       (lane_y),
    .lane_z       (lane_z),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_accepted (out_accepted),
    .out_sum_x    (out_sum_x),
    .out_sum_y    (out_sum_y),
    .out_sum_z    (out_sum_z)
  );

  // A rejected frame must leave all three sums untouched.
  assert property (@(posedge clk) disable iff (!rst_n)
    (move1 && !s1_ok_r) |=> (out_sum_x == $past(out_sum_x))
      && (out_sum_y == $past(out_sum_y)) && (out_sum_z == $past(out_sum_z)))
    else $error("sums changed on a rejected frame");

  // Storing into the last slot wraps the pointer and marks the ring full.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_ok && (wr_idx_r == LAST_IDX)) |=> ((wr_idx_r == '0) && full_r))
    else $error("write pointer did not wrap into the full state");

  // With stage one empty the block must be able to take a transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with an empty pipeline");

endmodule

// File: tb/mws_window_checker.sv
// Checker for the magnetometer window sum block: watches both channels,
// predicts each result from its own copy of the ring and totals, and compares.
// Depends on mws_pkg for the field types and status bit positions.
module mws_window_checker #(
  parameter int unsigned WINDOW_DEPTH = mws_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mws_pkg::status_t    in_ready_status,
  input  mws_pkg::sample_t    in_axis_a,
  input  mws_pkg::sample_t    in_axis_b,
  input  mws_pkg::sample_t    in_axis_c,
  input  mws_pkg::status_t    in_overflow_status,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mws_pkg::sum_t       out_sum_x,
  input  mws_pkg::sum_t       out_sum_y,
  input  mws_pkg::sum_t       out_sum_z,
  input  logic                out_accepted,
  output int unsigned         fail_count,
  output int unsigned         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    mws_pkg::sum_t sx;
    mws_pkg::sum_t sy;
    mws_pkg::sum_t sz;
    logic          acc;
  } window_result_t;

  mws_pkg::sample_t ring_x [WINDOW_DEPTH];
  mws_pkg::sample_t ring_y [WINDOW_DEPTH];
  mws_pkg::sample_t ring_z [WINDOW_DEPTH];
  int unsigned      slot_idx;
  mws_pkg::sum_t    tot_x, tot_y, tot_z;
  window_result_t   expected_sums [$];
  int unsigned      mismatch_count;

  function automatic mws_pkg::sum_t widen(input mws_pkg::sample_t s);
    return {{(mws_pkg::SUM_W-mws_pkg::SAMPLE_W){s[mws_pkg::SAMPLE_W-1]}}, s};
  endfunction

  // Applies one frame to the shadow window and returns the result it causes.
  function automatic window_result_t slide_window(input mws_pkg::status_t rs,
                                                  input mws_pkg::sample_t a,
                                                  input mws_pkg::sample_t b,
                                                  input mws_pkg::sample_t c,
                                                  input mws_pkg::status_t os);
    window_result_t r;
    logic ok;
    ok = rs[mws_pkg::READY_BIT] && !os[mws_pkg::OVERFLOW_BIT];
    if (ok) begin
      tot_x = tot_x - widen(ring_x[slot_idx]) + widen(c);
      tot_y = tot_y - widen(ring_y[slot_idx]) + widen(a);
      tot_z = tot_z - widen(ring_z[slot_idx]) + widen(b);
      ring_x[slot_idx] = c;
      ring_y[slot_idx] = a;
      ring_z[slot_idx] = b;
      slot_idx = (slot_idx == WINDOW_DEPTH - 1) ? 0 : slot_idx + 1;
    end
    r.sx  = tot_x;
    r.sy  = tot_y;
    r.sz  = tot_z;
    r.acc = ok;
    return r;
  endfunction

  always @(posedge clk) begin
    window_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        ring_x[i] = '0;
        ring_y[i] = '0;
        ring_z[i] = '0;
      end
      slot_idx = 0;
      tot_x = '0;
      tot_y = '0;
      tot_z = '0;
      expected_sums.delete();
    end else begin
      // The input is handled first so a result that comes out together with its own frame would still line up.
      if (in_valid && in_ready)
        expected_sums.push_back(slide_window(in_ready_status, in_axis_a, in_axis_b,
                                             in_axis_c, in_overflow_status));
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with no frame outstanding: x=%0d y=%0d z=%0d acc=%0b",
                     $realtime, out_sum_x, out_sum_y, out_sum_z, out_accepted);
        end else begin
          want = expected_sums.pop_front();
          if (out_sum_x !== want.sx || out_sum_y !== want.sy ||
              out_sum_z !== want.sz || out_accepted !== want.acc) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: expected x=%0d y=%0d z=%0d acc=%0b, got x=%0d y=%0d z=%0d acc=%0b",
                       $realtime, want.sx, want.sy, want.sz, want.acc,
                       out_sum_x, out_sum_y, out_sum_z, out_accepted);
          end
        end
      end
    end
    fail_count    <= mismatch_count;
    pending_count <= expected_sums.size();
  end

endmodule

// File: tb/magnetometer_window_sum_top_tb.sv
// Top of the magnetometer window sum testbench: clock, reset, frame stimulus,
// receiver back-pressure and the final verdict.
// Depends on mws_pkg, the block under test and mws_window_checker.
module magnetometer_window_sum_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = mws_pkg::DEFAULT_WINDOW_DEPTH;
  localparam int unsigned RANDOM_ITEMS = 1600;
  // Worst case is roughly every transaction seeing the longest sender gap and
  // the longest receiver stall; the limit sits several times above that.
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 16;

  localparam mws_pkg::sample_t S_MAX = 16'sh7FFF;
  localparam mws_pkg::sample_t S_MIN = 16'sh8000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  mws_pkg::status_t in_ready_status;
  mws_pkg::sample_t in_axis_a;
  mws_pkg::sample_t in_axis_b;
  mws_pkg::sample_t in_axis_c;
  mws_pkg::status_t in_overflow_status;
  logic             out_valid;
  logic             out_ready;
  mws_pkg::sum_t    out_sum_x;
  mws_pkg::sum_t    out_sum_y;
  mws_pkg::sum_t    out_sum_z;
  logic             out_accepted;

  int unsigned fail_count;
  int unsigned pending_count;

  // Testbench-only controls for the receiver.
  bit          no_idle;    // when set, neither side inserts gaps
  bit          hold_req;   // asks the hold-off process for one long stall
  bit          rx_hold;    // receiver is held off while this is set
  int unsigned cycle_count;

  magnetometer_window_sum_top #(
    .WINDOW_DEPTH(DEPTH)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_ready_status    (in_ready_status),
    .in_axis_a          (in_axis_a),
    .in_axis_b          (in_axis_b),
    .in_axis_c          (in_axis_c),
    .in_overflow_status (in_overflow_status),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sum_x          (out_sum_x),
    .out_sum_y          (out_sum_y),
    .out_sum_z          (out_sum_z),
    .out_accepted       (out_accepted)
  );

  mws_window_checker #(
    .WINDOW_DEPTH(DEPTH)
  ) window_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_ready_status    (in_ready_status),
    .in_axis_a          (in_axis_a),
    .in_axis_b          (in_axis_b),
    .in_axis_c          (in_axis_c),
    .in_overflow_status (in_overflow_status),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sum_x          (out_sum_x),
    .out_sum_y          (out_sum_y),
    .out_sum_z          (out_sum_z),
    .out_accepted       (out_accepted),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or a few cycles, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Presents one frame at the falling edge and holds it until the block takes
  // the transaction. in_ready is sampled at the rising edge, before the block
  // updates it, so the acceptance test sees the value at the edge itself.
  task automatic offer_frame(input mws_pkg::status_t rs, input mws_pkg::sample_t a,
                             input mws_pkg::sample_t b, input mws_pkg::sample_t c,
                             input mws_pkg::status_t os);
    @(negedge clk);
    in_ready_status    <= rs;
    in_axis_a          <= a;
    in_axis_b          <= b;
    in_axis_c          <= c;
    in_overflow_status <= os;
    in_valid           <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid for a gap whose length is given by n; each falling edge gets a single assignment.
  task automatic idle_sender(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Picks a sample according to the style of the current random segment.
  // The constant styles drive the totals to their extremes once the ring is full.
  function automatic mws_pkg::sample_t pick_sample(input int unsigned style);
    case (style)
      1: begin
        return S_MAX;
      end
      2: begin
        return S_MIN;
      end
      3: begin
        return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
      end
      default: begin
        return mws_pkg::sample_t'($urandom);
      end
    endcase
  endfunction

  // Receiver: random stalls of random length, none while no_idle is set, and
  // a solid hold-off while rx_hold is set.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (no_idle) begin
        stall_left = 0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = gap_len();
      end
    end
  end

  // Long receiver hold-off, counted in its own process so that the sender keeps
  // offering frames and the block has to back up and drop in_ready.
  initial begin
    rx_hold = 1'b0;
    wait (hold_req);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned      style;
    int unsigned      seg_left;
    int unsigned      r;
    mws_pkg::status_t rs;
    mws_pkg::status_t os;

    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_ready_status    = '0;
    in_axis_a          = '0;
    in_axis_b          = '0;
    in_axis_c          = '0;
    in_overflow_status = '0;
    no_idle            = 1'b0;
    hold_req           = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames. The first few check the axis remap with distinct values,
    // then the sample extremes, then each way a frame can be rejected, including
    // status bytes where only the unrelated bits are set.
    offer_frame(8'h01, 16'sd1, 16'sd2, 16'sd3, 8'h00);
    offer_frame(8'h01, S_MAX, S_MIN, 16'sd0, 8'h00);
    offer_frame(8'h01, S_MIN, S_MAX, S_MAX, 8'h00);
    offer_frame(8'h01, S_MIN, S_MIN, S_MIN, 8'h00);
    offer_frame(8'h01, S_MAX, S_MAX, S_MAX, 8'h00);
    offer_frame(8'h01, -16'sd1, -16'sd1, -16'sd1, 8'h00);
    // Data not ready.
    offer_frame(8'h00, 16'sd100, 16'sd200, 16'sd300, 8'h00);
    offer_frame(8'hFE, S_MAX, S_MAX, S_MAX, 8'h00);
    // Overflow flagged.
    offer_frame(8'h01, S_MIN, S_MIN, S_MIN, 8'h08);
    offer_frame(8'hFF, 16'sd7, 16'sd8, 16'sd9, 8'hFF);
    // Both reasons at once.
    offer_frame(8'h00, 16'sd5, 16'sd5, 16'sd5, 8'h08);
    // Every other status bit set, but the frame is still good.
    offer_frame(8'hFF, 16'sd1234, -16'sd4321, 16'sd77, 8'hF7);
    offer_frame(8'h01, 16'sd0, 16'sd0, 16'sd0, 8'h00);
    offer_frame(8'hAB, -16'sd2, 16'sd3, -16'sd4, 8'h54);
    // A rejected frame right between two good ones.
    offer_frame(8'h01, 16'sd10, 16'sd20, 16'sd30, 8'h00);
    offer_frame(8'h01, 16'sd11, 16'sd21, 16'sd31, 8'h0C);
    offer_frame(8'h01, 16'sd12, 16'sd22, 16'sd32, 8'h00);
    idle_sender(3);

    // Random part, built from segments of one sample style. Mostly good frames
    // so the ring fills, wraps and the totals reach their extremes.
    style    = 0;
    seg_left = 0;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (seg_left == 0) begin
        r        = $urandom_range(0, 9);
        style    = (r < 5) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : 3;
        seg_left = $urandom_range(50, 350);
      end
      seg_left--;

      // Pressure points: one long receiver hold-off, one full drain by the
      // sender, and a stretch with no gaps on either side.
      if (i == 400) hold_req = 1'b1;
      if (i == 800) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_count == 0);
      end
      no_idle = (i >= 1000 && i < 1200);

      r  = $urandom_range(0, 99);
      rs = mws_pkg::status_t'($urandom);
      os = mws_pkg::status_t'($urandom);
      if (r < 82) begin
        rs[mws_pkg::READY_BIT]    = 1'b1;
        os[mws_pkg::OVERFLOW_BIT] = 1'b0;
      end else if (r < 89) begin
        rs[mws_pkg::READY_BIT] = 1'b0;
      end else if (r < 96) begin
        rs[mws_pkg::READY_BIT]    = 1'b1;
        os[mws_pkg::OVERFLOW_BIT] = 1'b1;
      end

      offer_frame(rs, pick_sample(style), pick_sample(style), pick_sample(style), os);
      if (!no_idle) idle_sender(gap_len());
    end

    // Drain: every transaction must come back, then a last wait catches
    // any stray result before the verdict.
    @(negedge clk);
    in_valid <= 1'b0;
    no_idle = 1'b0;
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
